/* hdl/radial_vignette_pixel_core_assert.svh */
// Assertion macros shared by the radial vignette RTL.
// Each macro expands to one labeled concurrent assertion on the core clock.
`ifndef RADIAL_VIGNETTE_PIXEL_CORE_ASSERT_SVH
`define RADIAL_VIGNETTE_PIXEL_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RVP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RVP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/rvp_pkg.sv */
// Shared constants and beat types of the radial vignette pixel core.
// Used by the square-root cell, the divider cell and the top level.
`timescale 1ns / 1ps
`default_nettype none

package rvp_pkg;

   localparam int MAX_DIM        = 4096;
   localparam int SQRT_FRAC_BITS = 8;
   localparam int DIM_W          = 13;
   localparam int COORD_W        = 12;
   localparam int CHAN_W         = 8;
   localparam int CHANNELS       = 3;
   localparam int DELTA_W        = 13;
   localparam int SQUARE_W       = 2 * DELTA_W;
   localparam int RAD_W          = 28;
   localparam int SQRT_STEPS     = RAD_W / 2 + SQRT_FRAC_BITS;
   localparam int ROOT_W         = SQRT_STEPS;
   localparam int REM_W          = ROOT_W + 3;
   localparam int DIV_STEPS      = CHAN_W;
   localparam int DEN_W          = DIM_W + 1 + SQRT_FRAC_BITS;
   localparam int DSH_W          = DEN_W + DIV_STEPS - 1;
   localparam int NUM_W          = DEN_W + CHAN_W;

   typedef enum logic [0:0] {
      CSR_ROWS = 1'b0,
      CSR_COLS = 1'b1
   } csr_index_type;

   typedef logic [CHANNELS-1:0][CHAN_W-1:0] rgb_type;

   typedef struct packed {
      logic              valid;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      logic [RAD_W-1:0]  rad;
      rgb_type           rgb;
   } sqrt_beat_type;

   typedef struct packed {
      logic                             valid;
      logic                             kill;
      logic [DSH_W-1:0]                 dsh;
      logic [CHANNELS-1:0][NUM_W-1:0]   num;
      logic [CHANNELS-1:0][CHAN_W-1:0]  quo;
   } div_beat_type;

endpackage

`default_nettype wire

/* hdl/rvp_sqrt_cell.sv */
// One digit step of the bit-pair square root, registered.
// Depends on rvp_pkg for the beat type.
`timescale 1ns / 1ps
`default_nettype none

module rvp_sqrt_cell (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   enable,
   input  rvp_pkg::sqrt_beat_type beat_in,
   output rvp_pkg::sqrt_beat_type beat_out
);

   rvp_pkg::sqrt_beat_type          beat_ff;
   rvp_pkg::sqrt_beat_type          beat_in_nxt;
   logic [rvp_pkg::REM_W-1:0]       rem_sh;
   logic [rvp_pkg::REM_W-1:0]       trial;
   logic                            take;

   always_comb begin
      rem_sh = {beat_in.rem[rvp_pkg::REM_W-3:0], beat_in.rad[rvp_pkg::RAD_W-1 -: 2]};
      trial  = {1'b0, beat_in.root, 2'b01};
      take   = (rem_sh >= trial);
      beat_in_nxt       = beat_in;
      beat_in_nxt.rem   = take ? (rem_sh - trial) : rem_sh;
      beat_in_nxt.root  = {beat_in.root[rvp_pkg::ROOT_W-2:0], take};
      beat_in_nxt.rad   = {beat_in.rad[rvp_pkg::RAD_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else if (enable) begin
         beat_ff <= beat_in_nxt;
      end
   end

   assign beat_out = beat_ff;

endmodule

`default_nettype wire

/* hdl/rvp_div_cell.sv */
// One quotient bit of the restoring divide for all three channels, registered.
// Depends on rvp_pkg for the beat type.
`timescale 1ns / 1ps
`default_nettype none

module rvp_div_cell (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  enable,
   input  rvp_pkg::div_beat_type beat_in,
   output rvp_pkg::div_beat_type beat_out
);

   rvp_pkg::div_beat_type             beat_ff;
   rvp_pkg::div_beat_type             beat_in_nxt;
   logic [rvp_pkg::NUM_W-1:0]         dsh_ext;
   logic [rvp_pkg::CHANNELS-1:0]      take;

   always_comb begin
      dsh_ext     = {{(rvp_pkg::NUM_W - rvp_pkg::DSH_W){1'b0}}, beat_in.dsh};
      beat_in_nxt = beat_in;
      for (int ch = 0; ch < rvp_pkg::CHANNELS; ch++) begin
         take[ch] = (beat_in.num[ch] >= dsh_ext);
         beat_in_nxt.num[ch] = take[ch] ? (beat_in.num[ch] - dsh_ext) : beat_in.num[ch];
         beat_in_nxt.quo[ch] = {beat_in.quo[ch][rvp_pkg::CHAN_W-2:0], take[ch]};
      end
      beat_in_nxt.dsh = beat_in.dsh >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff.valid <= 1'b0;
      end else if (enable) begin
         beat_ff <= beat_in_nxt;
      end
   end

   assign beat_out = beat_ff;

endmodule

`default_nettype wire

/* hdl/radial_vignette_pixel_core.sv */
// Top level of the radial vignette pixel core: registers, front end and cell chains.
// Depends on rvp_pkg, rvp_sqrt_cell, rvp_div_cell and the assertion header.
//
// Usage: each beat on the req_ channel is one RGB pixel with its row and column.
// Each beat on the rsp_ channel is that pixel darkened by its distance from the
// image center, in the same order, one result per pixel.
// Image height and width are written on the csr_ port while no pixel is in flight;
// values above 4096 are clamped to 4096.
// From an accepted request beat to a valid response beat, each pixel passes
// two front-end stages, 22 square-root cells, one multiply stage and 8 divider cells.
// Throughput is one pixel per cycle while the receiver does not stall; the whole chain advances together.
// When the receiver stalls with a response waiting, the chain freezes and
// req_ready drops in the same cycle; it resumes with no beat lost.
// Reset clears all valid bits and sets height and width to 1.
`timescale 1ns / 1ps
`default_nettype none

`include "radial_vignette_pixel_core_assert.svh"

module radial_vignette_pixel_core (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         csr_we,
   input  wire [0:0]                   csr_index,
   input  wire [rvp_pkg::DIM_W-1:0]    csr_wdata,
   input  wire                         req_valid,
   output logic                        req_ready,
   input  wire [rvp_pkg::COORD_W-1:0]  req_pixel_row,
   input  wire [rvp_pkg::COORD_W-1:0]  req_pixel_col,
   input  wire [rvp_pkg::CHAN_W-1:0]   req_red_in,
   input  wire [rvp_pkg::CHAN_W-1:0]   req_green_in,
   input  wire [rvp_pkg::CHAN_W-1:0]   req_blue_in,
   output logic                        rsp_valid,
   input  wire                         rsp_ready,
   output logic [rvp_pkg::CHAN_W-1:0]  rsp_red_out,
   output logic [rvp_pkg::CHAN_W-1:0]  rsp_green_out,
   output logic [rvp_pkg::CHAN_W-1:0]  rsp_blue_out
);

   logic [rvp_pkg::DIM_W-1:0]      rows_ff;
   logic [rvp_pkg::DIM_W-1:0]      cols_ff;
   logic [rvp_pkg::DIM_W-1:0]      csr_clamped;
   logic                           advance;

   logic                           a_valid_ff;
   logic [rvp_pkg::DELTA_W-1:0]    a_dx_ff;
   logic [rvp_pkg::DELTA_W-1:0]    a_dy_ff;
   rvp_pkg::rgb_type               a_rgb_ff;
   logic [rvp_pkg::DELTA_W-1:0]    a_dx_in;
   logic [rvp_pkg::DELTA_W-1:0]    a_dy_in;
   logic [rvp_pkg::DIM_W-1:0]      col2;
   logic [rvp_pkg::DIM_W-1:0]      row2;

   logic                           b_valid_ff;
   logic [rvp_pkg::SQUARE_W-1:0]   b_sqx_ff;
   logic [rvp_pkg::SQUARE_W-1:0]   b_sqy_ff;
   rvp_pkg::rgb_type               b_rgb_ff;

   rvp_pkg::sqrt_beat_type         sq_b [0:rvp_pkg::SQRT_STEPS];
   rvp_pkg::div_beat_type          dv_b [0:rvp_pkg::DIV_STEPS];
   rvp_pkg::sqrt_beat_type         sq_last;
   rvp_pkg::div_beat_type          dv_last;
   rvp_pkg::div_beat_type          m_in;
   rvp_pkg::div_beat_type          m_ff;
   logic [rvp_pkg::DEN_W-1:0]      den;
   logic [rvp_pkg::DEN_W-1:0]      root_ext;
   logic [rvp_pkg::DEN_W-1:0]      span;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   assign csr_clamped = (csr_wdata > rvp_pkg::DIM_W'(rvp_pkg::MAX_DIM))
                        ? rvp_pkg::DIM_W'(rvp_pkg::MAX_DIM) : csr_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= rvp_pkg::DIM_W'(1);
         cols_ff <= rvp_pkg::DIM_W'(1);
      end else if (csr_we) begin
         unique case (rvp_pkg::csr_index_type'(csr_index))
            rvp_pkg::CSR_ROWS: rows_ff <= csr_clamped;
            rvp_pkg::CSR_COLS: cols_ff <= csr_clamped;
            default:           rows_ff <= rows_ff;
         endcase
      end
   end

   always_comb begin
      col2    = {req_pixel_col, 1'b0};
      row2    = {req_pixel_row, 1'b0};
      a_dx_in = (col2 >= cols_ff) ? (col2 - cols_ff) : (cols_ff - col2);
      a_dy_in = (row2 >= rows_ff) ? (row2 - rows_ff) : (rows_ff - row2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_valid;
         a_dx_ff    <= a_dx_in;
         a_dy_ff    <= a_dy_in;
         a_rgb_ff   <= {req_blue_in, req_green_in, req_red_in};
         b_valid_ff <= a_valid_ff;
         b_sqx_ff   <= a_dx_ff * a_dx_ff;
         b_sqy_ff   <= a_dy_ff * a_dy_ff;
         b_rgb_ff   <= a_rgb_ff;
      end
   end

   always_comb begin
      sq_b[0].valid = b_valid_ff;
      sq_b[0].rem   = '0;
      sq_b[0].root  = '0;
      sq_b[0].rad   = rvp_pkg::RAD_W'(b_sqx_ff) + rvp_pkg::RAD_W'(b_sqy_ff);
      sq_b[0].rgb   = b_rgb_ff;
   end

   for (genvar i = 0; i < rvp_pkg::SQRT_STEPS; i++) begin : g_sqrt
      rvp_sqrt_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (advance),
         .beat_in  (sq_b[i]),
         .beat_out (sq_b[i+1])
      );
   end

   assign sq_last = sq_b[rvp_pkg::SQRT_STEPS];

   always_comb begin
      den      = {rows_ff, {(rvp_pkg::SQRT_FRAC_BITS + 1){1'b0}}};
      root_ext = sq_last.root;
      span     = den - root_ext;
      m_in.valid = sq_last.valid;
      m_in.kill  = (root_ext >= den);
      m_in.dsh   = {den, {(rvp_pkg::DIV_STEPS - 1){1'b0}}};
      m_in.quo   = '0;
      for (int ch = 0; ch < rvp_pkg::CHANNELS; ch++) begin
         m_in.num[ch] = sq_last.rgb[ch] * span;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_ff.valid <= 1'b0;
      end else if (advance) begin
         m_ff <= m_in;
      end
   end

   assign dv_b[0] = m_ff;

   for (genvar j = 0; j < rvp_pkg::DIV_STEPS; j++) begin : g_div
      rvp_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (advance),
         .beat_in  (dv_b[j]),
         .beat_out (dv_b[j+1])
      );
   end

   assign dv_last = dv_b[rvp_pkg::DIV_STEPS];

   always_comb begin
      rsp_valid     = dv_last.valid;
      rsp_red_out   = dv_last.kill ? '0 : dv_last.quo[0];
      rsp_green_out = dv_last.kill ? '0 : dv_last.quo[1];
      rsp_blue_out  = dv_last.kill ? '0 : dv_last.quo[2];
   end

   `RVP_ASSERT_NOW(a_rows_clamped, clock, reset, 1'b1, rows_ff <= rvp_pkg::DIM_W'(4096), "height")
   `RVP_ASSERT_NOW(a_cols_clamped, clock, reset, 1'b1, cols_ff <= rvp_pkg::DIM_W'(4096), "width")
   `RVP_ASSERT_NEXT(a_req_enters, clock, reset, req_valid && req_ready, a_valid_ff, "beat lost")
   `RVP_ASSERT_NOW(a_root_exact, clock, reset, sq_last.valid, sq_last.rem <= {sq_last.root, 1'b0}, "rem")
   `RVP_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready, $stable(dv_last), "stall")

endmodule

`default_nettype wire

/* dv/tb_radial_vignette_pixel_core.sv */
// Self-checking testbench of the radial vignette pixel core: directed table, then random pixels.
// Depends on rvp_pkg and radial_vignette_pixel_core; holds its own shading predictor.
`timescale 1ns / 1ps
`default_nettype none

module tb_radial_vignette_pixel_core;

   typedef struct {
      logic [rvp_pkg::COORD_W-1:0] row;
      logic [rvp_pkg::COORD_W-1:0] col;
      logic [rvp_pkg::CHAN_W-1:0]  red;
      logic [rvp_pkg::CHAN_W-1:0]  green;
      logic [rvp_pkg::CHAN_W-1:0]  blue;
      bit                          typed;
      logic [rvp_pkg::CHAN_W-1:0]  red_x;
      logic [rvp_pkg::CHAN_W-1:0]  green_x;
      logic [rvp_pkg::CHAN_W-1:0]  blue_x;
   } pixel_row_type;

   typedef struct {
      logic [rvp_pkg::CHAN_W-1:0] red;
      logic [rvp_pkg::CHAN_W-1:0] green;
      logic [rvp_pkg::CHAN_W-1:0] blue;
   } shaded_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [0:0] csr_index = rvp_pkg::CSR_ROWS;
   logic [rvp_pkg::DIM_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   wire req_ready;
   logic [rvp_pkg::COORD_W-1:0] req_pixel_row = '0;
   logic [rvp_pkg::COORD_W-1:0] req_pixel_col = '0;
   logic [rvp_pkg::CHAN_W-1:0] req_red_in = '0;
   logic [rvp_pkg::CHAN_W-1:0] req_green_in = '0;
   logic [rvp_pkg::CHAN_W-1:0] req_blue_in = '0;
   wire rsp_valid;
   logic rsp_ready = 1'b0;
   wire [rvp_pkg::CHAN_W-1:0] rsp_red_out;
   wire [rvp_pkg::CHAN_W-1:0] rsp_green_out;
   wire [rvp_pkg::CHAN_W-1:0] rsp_blue_out;

   shaded_type pending_shades[$];
   int unsigned height_reg;
   int unsigned width_reg;
   int mismatches = 0;
   bit quiet_tail = 1'b0;

   radial_vignette_pixel_core uut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_pixel_row(req_pixel_row), .req_pixel_col(req_pixel_col),
      .req_red_in(req_red_in), .req_green_in(req_green_in), .req_blue_in(req_blue_in),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_red_out(rsp_red_out), .rsp_green_out(rsp_green_out),
      .rsp_blue_out(rsp_blue_out)
   );

   always #1 clock = ~clock;

   function automatic longint unsigned root_q8(longint unsigned radicand);
      longint unsigned root;
      longint unsigned rem;
      longint unsigned trial;
      longint unsigned pair;
      int pos;
      root = 0;
      rem = 0;
      for (int k = 0; k < 20 + rvp_pkg::SQRT_FRAC_BITS; k++) begin
         pos = 19 - k;
         pair = (pos >= 0) ? ((radicand >> (2 * pos)) & 3) : 0;
         rem = (rem << 2) | pair;
         trial = (root << 2) | 1;
         if (rem >= trial) begin
            rem -= trial;
            root = (root << 1) | 1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   function automatic logic [rvp_pkg::CHAN_W-1:0] darken(logic [rvp_pkg::CHAN_W-1:0] c,
         longint unsigned r, longint unsigned d);
      if (r >= d) return '0;
      return rvp_pkg::CHAN_W'((longint'(c) * (d - r)) / d);
   endfunction

   function automatic shaded_type vignette(logic [rvp_pkg::COORD_W-1:0] row,
         logic [rvp_pkg::COORD_W-1:0] col, logic [rvp_pkg::CHAN_W-1:0] red,
         logic [rvp_pkg::CHAN_W-1:0] green, logic [rvp_pkg::CHAN_W-1:0] blue);
      longint unsigned dx;
      longint unsigned dy;
      longint unsigned r;
      longint unsigned d;
      shaded_type s;
      dx = (2 * col >= width_reg) ? 2 * col - width_reg : width_reg - 2 * col;
      dy = (2 * row >= height_reg) ? 2 * row - height_reg : height_reg - 2 * row;
      r = root_q8(dx * dx + dy * dy);
      d = (2 * longint'(height_reg)) << rvp_pkg::SQRT_FRAC_BITS;
      s.red = darken(red, r, d);
      s.green = darken(green, r, d);
      s.blue = darken(blue, r, d);
      return s;
   endfunction

   task automatic write_dim(rvp_pkg::csr_index_type idx, logic [rvp_pkg::DIM_W-1:0] value);
      int unsigned v;
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      v = (value > rvp_pkg::MAX_DIM) ? rvp_pkg::MAX_DIM : value;
      if (idx == rvp_pkg::CSR_ROWS) height_reg = v;
      else width_reg = v;
   endtask

   task automatic send_pixel(pixel_row_type p);
      shaded_type s;
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pixel_row <= p.row;
      req_pixel_col <= p.col;
      req_red_in <= p.red;
      req_green_in <= p.green;
      req_blue_in <= p.blue;
      do @(posedge clock); while (!req_ready);
      if (p.typed) begin
         s.red = p.red_x;
         s.green = p.green_x;
         s.blue = p.blue_x;
      end else begin
         s = vignette(p.row, p.col, p.red, p.green, p.blue);
      end
      pending_shades.push_back(s);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_shades.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   always @(posedge clock) begin
      shaded_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_shades.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected beat %0d %0d %0d",
               rsp_red_out, rsp_green_out, rsp_blue_out);
         end else begin
            e = pending_shades.pop_front();
            if (e.red !== rsp_red_out || e.green !== rsp_green_out
                  || e.blue !== rsp_blue_out) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %0d %0d %0d, got %0d %0d %0d",
                     e.red, e.green, e.blue, rsp_red_out, rsp_green_out, rsp_blue_out);
            end
         end
      end
   end

   initial begin
      int gap;
      gap = 0;
      forever begin
         @(negedge clock);
         if (quiet_tail) rsp_ready <= 1'b1;
         else if (gap > 0) begin
            rsp_ready <= 1'b0;
            gap--;
         end else if ($urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            gap = $urandom_range(0, 4);
         end else rsp_ready <= 1'b1;
      end
   end

   initial begin
      #4000000;
      $display("FAIL radial_vignette_pixel_core");
      $finish;
   end

   initial begin
      pixel_row_type directed[$];
      pixel_row_type p;
      int unsigned dims[$];
      height_reg = 1;
      width_reg = 1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // After reset the image is 1x1; every pixel at least one row from the center is black.
      directed = '{
         '{0, 0, 255, 255, 255, 0, 0, 0, 0},
         '{4095, 4095, 255, 255, 255, 1, 0, 0, 0},
         '{0, 4095, 128, 64, 32, 1, 0, 0, 0},
         '{4095, 0, 1, 2, 3, 1, 0, 0, 0},
         '{1, 1, 0, 0, 0, 1, 0, 0, 0}
      };
      foreach (directed[i]) send_pixel(directed[i]);
      drain();

      // A zero height blacks out the whole image.
      write_dim(rvp_pkg::CSR_ROWS, rvp_pkg::DIM_W'(0));
      write_dim(rvp_pkg::CSR_COLS, rvp_pkg::DIM_W'(0));
      send_pixel('{0, 0, 255, 255, 255, 1, 0, 0, 0});
      send_pixel('{2048, 2048, 255, 128, 1, 1, 0, 0, 0});
      drain();

      // Oversized dimensions clamp to the maximum; center pixels keep full intensity.
      write_dim(rvp_pkg::CSR_ROWS, 13'h1FFF);
      write_dim(rvp_pkg::CSR_COLS, 13'h1FFF);
      send_pixel('{2048, 2048, 255, 170, 85, 1, 255, 170, 85});
      send_pixel('{0, 0, 255, 255, 255, 0, 0, 0, 0});
      send_pixel('{4095, 4095, 255, 255, 255, 0, 0, 0, 0});
      send_pixel('{0, 2048, 200, 100, 50, 0, 0, 0, 0});
      send_pixel('{4095, 0, 255, 0, 255, 0, 0, 0, 0});
      drain();
      write_dim(rvp_pkg::CSR_ROWS, rvp_pkg::DIM_W'(4097));
      write_dim(rvp_pkg::CSR_COLS, rvp_pkg::DIM_W'(1));
      send_pixel('{100, 0, 255, 255, 255, 0, 0, 0, 0});
      drain();

      dims = '{1, 2, 3, 7, 16, 64, 480, 640, 1080, 4095, 4096};
      for (int phase = 0; phase < 11; phase++) begin
         write_dim(rvp_pkg::CSR_ROWS, rvp_pkg::DIM_W'((phase == 10)
            ? $urandom_range(0, 8191) : dims[$urandom_range(0, 10)]));
         write_dim(rvp_pkg::CSR_COLS, rvp_pkg::DIM_W'((phase == 9)
            ? $urandom_range(0, 8191) : dims[$urandom_range(0, 10)]));
         if (phase == 10) quiet_tail = 1'b1;
         for (int n = 0; n < 150; n++) begin
            p.typed = 1'b0;
            if ($urandom_range(0, 3) == 0) begin
               p.row = rvp_pkg::COORD_W'($urandom());
               p.col = rvp_pkg::COORD_W'($urandom());
            end else begin
               p.row = rvp_pkg::COORD_W'($urandom_range(0,
                  (height_reg > 0) ? height_reg - 1 : 0));
               p.col = rvp_pkg::COORD_W'($urandom_range(0,
                  (width_reg > 0) ? width_reg - 1 : 0));
            end
            p.red = rvp_pkg::CHAN_W'($urandom());
            p.green = rvp_pkg::CHAN_W'($urandom());
            p.blue = rvp_pkg::CHAN_W'($urandom());
            send_pixel(p);
         end
         drain();
      end

      if (mismatches == 0) $display("PASS radial_vignette_pixel_core");
      else $display("FAIL radial_vignette_pixel_core");
      $finish;
   end
endmodule

`default_nettype wire
